// ----- hw/rtl/tcw_pkg.sv -----
// Package for the text console writer: action and control-byte codes,
// reset constants and the sequencer state type. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SETCUR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam int         TAB_STEP   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_INIT,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// Text console writer top level: cell buffer memory, cursor and sequencer.
// Depends on tcw_pkg.
`default_nettype none

// Command-style console engine. An item is taken when start is high and busy
// is low; its result appears for one cycle with done high and must be taken
// then. Put-char, set-cursor and read-cell pass from accept through an
// execute step with the buffer access and a result-formation step to the
// result beat; busy drops in the cycle that carries done, so a new item may
// enter there. Clear screen, and a put-char that scrolls, add one pass over
// the buffer memory, one cell per cycle through the single read and write
// port. After reset the buffer is blanked by a pass over every cell, during
// which busy is high; register writes are accepted throughout.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  cursor_x,
  input  wire logic [7:0]  cursor_y,
  input  wire logic [10:0] cell_index,
  output logic             done,
  output logic [4:0]       cursor_row,
  output logic [6:0]       cursor_col,
  output logic [10:0]      cursor_pos,
  output logic [15:0]      cell_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  state_t state, state_next;

  logic [7:0]  attribute;
  logic [15:0] fill_value;
  logic [ADDR_W-1:0] cnt;

  logic [1:0]  op_action;
  logic [7:0]  op_char;
  logic [7:0]  op_x;
  logic [7:0]  op_y;
  logic [10:0] op_index;
  logic        rd_ok;

  logic [ROW_W-1:0] row_now;
  logic [COL_W-1:0] col_now;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // delayed write of the scroll copy
  logic              sv_valid;
  logic [ADDR_W-1:0] sv_addr;
  logic              sv_blank;

  logic [15:0] blank_cell;
  assign blank_cell = {attribute, CH_SPACE};

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'b0, attribute} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_wr) begin
      attribute <= pwdata[7:0];
    end
  end

  // put-char cursor arithmetic
  logic [ROW_W:0]   row_inc;
  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   col_tab;
  logic [COL_W:0]   col_put;
  logic [ROW_W:0]   row_put;
  logic [COL_W:0]   col_wr;
  logic [ROW_W:0]   row_fix;
  logic [COL_W:0]   col_fix;
  logic             put_we;
  logic [15:0]      put_data;
  logic [ADDR_W-1:0] put_addr;
  logic             printable;
  logic [7:0]       x_clamp;
  logic [7:0]       y_clamp;

  assign row_inc   = {1'b0, row_now} + (ROW_W+1)'(1);
  assign col_inc   = {1'b0, col_now} + (COL_W+1)'(1);
  assign col_tab   = ({1'b0, col_now} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP-1);
  assign printable = (op_char[7] == 1'b0) && (op_char >= CH_SPACE);
  assign x_clamp   = (32'(op_x) >= COLUMNS) ? 8'(COLUMNS-1) : op_x;
  assign y_clamp   = (32'(op_y) >= ROWS) ? 8'(ROWS-1) : op_y;

  always_comb begin
    row_put  = {1'b0, row_now};
    col_put  = {1'b0, col_now};
    col_wr   = {1'b0, col_now};
    put_we   = 1'b0;
    put_data = blank_cell;
    if (op_char == CH_LF) begin
      row_put = row_inc;
      col_put = '0;
    end else if (op_char == CH_CR) begin
      col_put = '0;
    end else if (op_char == CH_TAB) begin
      col_put = col_tab;
    end else if (op_char == CH_BS) begin
      if (col_now != '0) begin
        col_put = {1'b0, col_now} - (COL_W+1)'(1);
      end
      col_wr = col_put;
      put_we = 1'b1;
    end else if (printable) begin
      put_we   = 1'b1;
      put_data = {attribute, op_char};
      col_put  = col_inc;
    end
    row_fix = row_put;
    col_fix = col_put;
    if (32'(col_put) >= COLUMNS) begin
      row_fix = row_put + (ROW_W+1)'(1);
      col_fix = '0;
    end
  end

  assign put_addr = ADDR_W'(32'(row_now) * COLUMNS + 32'(col_wr));

  // sequencer
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cnt;
    mem_wdata  = fill_value;
    mem_raddr  = ADDR_W'(op_index);
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        case (op_action)
          ACT_PUT: begin
            mem_we    = put_we;
            mem_waddr = put_addr;
            mem_wdata = put_data;
            if (32'(row_fix) >= ROWS) state_next = ST_SCROLL;
          end
          ACT_CLEAR: state_next = ST_CLEAR;
          default: ;
        endcase
      end
      ST_SCROLL: begin
        mem_raddr = ADDR_W'(32'(cnt) + COLUMNS);
        if (32'(cnt) == CELLS-1) state_next = ST_RESP;
      end
      ST_CLEAR, ST_INIT: begin
        mem_we = 1'b1;
        if (32'(cnt) == CELLS-1) state_next = (state == ST_INIT) ? ST_IDLE : ST_RESP;
      end
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (sv_valid) begin
      mem_we    = 1'b1;
      mem_waddr = sv_addr;
      mem_wdata = sv_blank ? fill_value : rdata;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      fill_value <= {ATTR_RESET, CH_SPACE};
      row_now    <= '0;
      col_now    <= '0;
      sv_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      sv_valid <= (state == ST_SCROLL);
      sv_addr  <= cnt;
      sv_blank <= (32'(cnt) >= CELLS - COLUMNS);
      done     <= (state == ST_RESP);
      if (state == ST_SCROLL || state == ST_CLEAR || state == ST_INIT) begin
        cnt <= cnt + ADDR_W'(1);
      end
      if (state == ST_IDLE && start) begin
        op_action <= action;
        op_char   <= char_code;
        op_x      <= cursor_x;
        op_y      <= cursor_y;
        op_index  <= cell_index;
        rd_ok     <= (action == ACT_READ) && (32'(cell_index) < CELLS);
      end
      if (state == ST_EXEC) begin
        cnt        <= '0;
        fill_value <= blank_cell;
        case (op_action)
          ACT_PUT: begin
            if (32'(row_fix) >= ROWS) begin
              row_now <= ROW_W'(ROWS-1);
              col_now <= '0;
            end else begin
              row_now <= ROW_W'(row_fix);
              col_now <= COL_W'(col_fix);
            end
          end
          ACT_CLEAR: begin
            row_now <= '0;
            col_now <= '0;
          end
          ACT_SETCUR: begin
            row_now <= ROW_W'(y_clamp);
            col_now <= COL_W'(x_clamp);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP) begin
      cursor_row <= 5'(row_now);
      cursor_col <= 7'(col_now);
      cursor_pos <= 11'(32'(row_now) * COLUMNS + 32'(col_now));
      cell_data  <= rd_ok ? rdata : 16'h0000;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_RESP))
    else $error("result beat without result state");

  a_copy_from_scroll: assert property (@(posedge clk) disable iff (rst)
    sv_valid |-> $past(state == ST_SCROLL))
    else $error("scroll copy write outside scroll pass");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row_now) < ROWS && 32'(col_now) < COLUMNS)
    else $error("cursor out of range");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !sv_valid) |-> !mem_we)
    else $error("buffer written while idle");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for text_console_writer: command beats with random idling,
// APB writes to the attribute register, and an in-order screen/cursor predictor.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [7:0] CH_TOP = 8'h7F;
  localparam logic [2:0] ATTR_ADDR = 3'd0;
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int STALL_LIMIT = 10 * CELLS;
  localparam int PHASE_ITEMS = 330;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic [10:0] cell_index;
    int          gap;
  } console_cmd_t;

  typedef struct {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] pos;
    logic [15:0] data;
  } cursor_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_READ;
  logic [7:0]  char_code = '0;
  logic [7:0]  cursor_x = '0;
  logic [7:0]  cursor_y = '0;
  logic [10:0] cell_index = '0;
  logic        done;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_pos;
  logic [15:0] cell_data;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .action(action), .char_code(char_code), .cursor_x(cursor_x),
    .cursor_y(cursor_y), .cell_index(cell_index),
    .done(done), .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cursor_pos(cursor_pos), .cell_data(cell_data)
  );

  console_cmd_t   pending_cmds[$];
  cursor_report_t expected_reports[$];
  console_cmd_t   cur_cmd;
  logic [15:0]    screen_cells[CELLS];
  logic [7:0]     text_attr;
  int             cur_row;
  int             cur_col;
  int             held_cycles = 0;
  int             no_gap_left = 0;
  int             stall_cycles = 0;
  int             errors = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void blank_rows(int first);
    int i;
    for (i = first * COLUMNS; i < CELLS; i++) screen_cells[i] = {text_attr, CH_SPACE};
  endfunction

  function automatic void put_char(logic [7:0] c);
    int r;
    int k;
    int i;
    r = cur_row;
    k = cur_col;
    if (c == CH_LF) begin
      r++;
      k = 0;
    end else if (c == CH_CR) begin
      k = 0;
    end else if (c == CH_TAB) begin
      k = (k + TAB_STEP) & ~(TAB_STEP - 1);
    end else if (c == CH_BS) begin
      if (k != 0) k--;
      screen_cells[r * COLUMNS + k] = {text_attr, CH_SPACE};
    end else if (c >= CH_SPACE && c <= CH_TOP) begin
      screen_cells[r * COLUMNS + k] = {text_attr, c};
      k++;
    end
    if (k >= COLUMNS) begin
      r++;
      k = 0;
    end
    cur_row = r;
    cur_col = k;
    if (cur_row >= ROWS) begin
      for (i = COLUMNS; i < CELLS; i++) screen_cells[i - COLUMNS] = screen_cells[i];
      blank_rows(ROWS - 1);
      cur_row = ROWS - 1;
      cur_col = 0;
    end
  endfunction

  function automatic cursor_report_t apply_console_cmd(console_cmd_t c);
    cursor_report_t rep;
    int lin;
    rep.data = '0;
    case (c.action)
      ACT_PUT: put_char(c.char_code);
      ACT_CLEAR: begin
        blank_rows(0);
        cur_row = 0;
        cur_col = 0;
      end
      ACT_SETCUR: begin
        cur_col = (c.cursor_x >= COLUMNS) ? COLUMNS - 1 : int'(c.cursor_x);
        cur_row = (c.cursor_y >= ROWS) ? ROWS - 1 : int'(c.cursor_y);
      end
      default: begin
        if (c.cell_index < CELLS) rep.data = screen_cells[c.cell_index];
      end
    endcase
    lin = cur_row * COLUMNS + cur_col;
    rep.row = cur_row[4:0];
    rep.col = cur_col[6:0];
    rep.pos = lin[10:0];
    return rep;
  endfunction

  function automatic int draw_gap();
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(10, 60);
    return $urandom_range(0, 13);
  endfunction

  task automatic push_cmd(logic [1:0] act, logic [7:0] ch, logic [7:0] x, logic [7:0] y,
                          logic [10:0] idx);
    console_cmd_t c;
    c.action = act;
    c.char_code = ch;
    c.cursor_x = x;
    c.cursor_y = y;
    c.cell_index = idx;
    c.gap = draw_gap();
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_cmds(int count);
    int n;
    int pick;
    logic [1:0] act;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [10:0] idx;
    for (n = 0; n < count; n++) begin
      ch = $urandom_range(0, 255);
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
      idx = $urandom_range(0, 2047);
      pick = $urandom_range(0, 99);
      if (pick < 70) act = ACT_PUT;
      else if (pick < 72) act = ACT_CLEAR;
      else if (pick < 82) act = ACT_SETCUR;
      else act = ACT_READ;
      pick = $urandom_range(0, 99);
      if (act == ACT_PUT) begin
        if (pick < 62) ch = $urandom_range(CH_SPACE, CH_TOP);
        else if (pick < 67) ch = CH_LF;
        else if (pick < 71) ch = CH_CR;
        else if (pick < 77) ch = CH_TAB;
        else if (pick < 84) ch = CH_BS;
      end else if (act == ACT_SETCUR && pick < 50) begin
        x = $urandom_range(0, COLUMNS - 1);
        y = $urandom_range(0, 1) ? ROWS - 1 : $urandom_range(0, ROWS - 1);
      end else if (act == ACT_READ) begin
        if (pick < 50) idx = $urandom_range(0, CELLS - 1);
        else if (pick < 75) idx = $urandom_range((ROWS - 2) * COLUMNS, CELLS - 1);
        else if (pick < 88) idx = $urandom_range(0, COLUMNS - 1);
      end
      push_cmd(act, ch, x, y, idx);
    end
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ATTR_ADDR) text_attr = value[7:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_reports.size() != 0);
  endtask

  always @(posedge clk) begin : drive_cmds
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_reports.push_back(apply_console_cmd(cur_cmd));
        held_cycles = 0;
      end
      if (pending_cmds.size() != 0 && held_cycles >= pending_cmds[0].gap) begin
        cur_cmd = pending_cmds.pop_front();
        action <= cur_cmd.action;
        char_code <= cur_cmd.char_code;
        cursor_x <= cur_cmd.cursor_x;
        cursor_y <= cur_cmd.cursor_y;
        cell_index <= cur_cmd.cell_index;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        held_cycles++;
      end
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    cursor_report_t want;
    if (!rst && done === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("cursor_row", 16'(want.row), 16'(cursor_row));
        compare_field("cursor_col", 16'(want.col), 16'(cursor_col));
        compare_field("cursor_pos", 16'(want.pos), 16'(cursor_pos));
        compare_field("cell_data", want.data, cell_data);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done || (psel && penable && pwrite)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** text_console_writer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] attr_plan[5];
    int p;
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = $urandom_range(1, 254);
    attr_plan[3] = 8'h80;
    attr_plan[4] = $urandom_range(0, 255);
    text_attr = ATTR_RESET;
    cur_row = 0;
    cur_col = 0;
    blank_rows(0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - 1));
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS));
    push_cmd(ACT_READ, 8'hFF, 8'hFF, 8'hFF, 11'h7FF);
    push_cmd(ACT_PUT, 8'h41, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_TOP, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_SPACE, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, 8'h1F, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, 8'h80, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, 8'hFF, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_TAB, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_BS, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_CR, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_BS, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'd1);
    push_cmd(ACT_PUT, CH_LF, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_SETCUR, 8'h00, 8'(COLUMNS - 2), 8'h00, 11'd0);
    push_cmd(ACT_PUT, CH_TAB, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_SETCUR, 8'h00, 8'hFF, 8'hFF, 11'd0);
    push_cmd(ACT_PUT, 8'h5A, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'((ROWS - 1) * COLUMNS - 1));
    push_cmd(ACT_SETCUR, 8'h00, 8'd5, 8'(ROWS - 1), 11'd0);
    push_cmd(ACT_PUT, CH_LF, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0);
    push_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 11'd0);
    queue_random_cmds(PHASE_ITEMS - 30);
    wait_drained();

    for (p = 0; p < 5; p++) begin
      write_register(ATTR_ADDR, {24'($urandom), attr_plan[p]});
      if (p == 2) write_register(UNUSED_ADDR, $urandom);
      queue_random_cmds(PHASE_ITEMS);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer.sv
tb/tb.sv
